// ----- rtl/core/cbd_pkg.sv -----
// cbd_pkg: widths, CORDIC table and pipeline constants for the bearing block.
// Used by compass_bearing_degrees_top and cbd_checker; depends on nothing.
package cbd_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int TABLE_LEN       = 24;
    localparam int PRESCALE        = 24;
    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_CSTAGES     = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // difference of two coordinates
    localparam int DW  = COORD_WIDTH + 1;
    // CORDIC vector: difference, prescale, gain and pre-rotation headroom
    localparam int XW  = DW + PRESCALE + 4;
    // angle in degrees with 16 fraction bits
    localparam int ZW  = 26;
    localparam int DEGW = 11;
    localparam int BEARING_WIDTH = 9;

    // entry stage + CORDIC stages + round stage + wrap stage
    localparam int LATENCY = NUM_CSTAGES + 3;

    localparam logic signed [ZW-1:0] Z_90      = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] ROUND_ADD = ZW'(128);
    localparam logic signed [ZW-1:0] RAW_90    = ZW'(90 * 256);
    localparam logic signed [DEGW-1:0] DEG_360 = DEGW'(360);
    localparam logic [BEARING_WIDTH-1:0] BEARING_EQUAL = BEARING_WIDTH'(90);

    // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/compass_bearing_degrees_top.sv -----
// compass_bearing_degrees_top: pipelined CORDIC atan2 giving a whole-degree bearing.
// Depends on cbd_pkg for widths, the arctan table and the stage count.
// Pipeline: entry stage, 8 CORDIC stages of 2 steps each, round stage, wrap stage.
// Throughput: one word per cycle; busy stays low, since the receiver cannot stall.
// Reset: rst_n clears every stage valid bit and done at once; payload is not reset.
module compass_bearing_degrees_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [cbd_pkg::COORD_WIDTH-1:0]   start_x,
    input  logic signed [cbd_pkg::COORD_WIDTH-1:0]   start_y,
    input  logic signed [cbd_pkg::COORD_WIDTH-1:0]   end_x,
    input  logic signed [cbd_pkg::COORD_WIDTH-1:0]   end_y,
    output logic                                     done,
    output logic        [cbd_pkg::BEARING_WIDTH-1:0] bearing
);

    localparam int NCS  = cbd_pkg::NUM_CSTAGES;
    localparam int XW   = cbd_pkg::XW;
    localparam int ZW   = cbd_pkg::ZW;
    localparam int DW   = cbd_pkg::DW;
    localparam int DEGW = cbd_pkg::DEGW;
    localparam int CW   = cbd_pkg::COORD_WIDTH;
    localparam int PS   = cbd_pkg::PRESCALE;
    localparam int SPS  = cbd_pkg::STEPS_PER_STAGE;

    // Stage 0 is the entry stage; stage s+1 holds the vector after CORDIC stage s.
    logic signed [XW-1:0] x_reg    [0:NCS];
    logic signed [XW-1:0] x_next   [0:NCS];
    logic signed [XW-1:0] y_reg    [0:NCS];
    logic signed [XW-1:0] y_next   [0:NCS];
    logic signed [ZW-1:0] z_reg    [0:NCS];
    logic signed [ZW-1:0] z_next   [0:NCS];
    logic                 zero_reg [0:NCS];
    logic                 zero_next[0:NCS];
    logic [NCS:0]         valid_reg;
    logic [NCS:0]         valid_next;

    // round stage
    logic signed [ZW-1:0] raw_reg, raw_next;
    logic                 rzero_reg, rzero_next;
    logic                 rvalid_reg, rvalid_next;

    // wrap stage / output register
    logic                               done_reg, done_next;
    logic [cbd_pkg::BEARING_WIDTH-1:0]  bearing_reg, bearing_next;

    // The receiver cannot stall, so the pipeline always advances.
    assign busy = 1'b0;

    // Entry stage: form the differences, prescale, and pre-rotate the left half-plane.
    // CORDIC stages: each one runs SPS vectoring steps on the vector it holds.
    always_comb
    begin
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] xc;
        logic signed [XW-1:0] yc;
        logic signed [ZW-1:0] zc;
        logic signed [XW-1:0] xsh;
        logic signed [XW-1:0] ysh;
        dx = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
        dy = $signed({start_y[CW-1], start_y}) - $signed({end_y[CW-1], end_y});
        xs = {{(XW-DW-PS){dx[DW-1]}}, dx, {PS{1'b0}}};
        ys = {{(XW-DW-PS){dy[DW-1]}}, dy, {PS{1'b0}}};
        valid_next[0] = start;
        zero_next[0]  = (dx == '0) && (dy == '0);
        if (xs < 0) begin
            if (ys >= 0) begin
                x_next[0] = ys;
                y_next[0] = -xs;
                z_next[0] = cbd_pkg::Z_90;
            end
            else begin
                x_next[0] = -ys;
                y_next[0] = xs;
                z_next[0] = -cbd_pkg::Z_90;
            end
        end
        else begin
            x_next[0] = xs;
            y_next[0] = ys;
            z_next[0] = '0;
        end
        for (int s = 0; s < NCS; s++) begin
            xc = x_reg[s];
            yc = y_reg[s];
            zc = z_reg[s];
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < cbd_pkg::CORDIC_STEPS) begin
                    xsh = xc >>> (s * SPS + j);
                    ysh = yc >>> (s * SPS + j);
                    if (yc >= 0) begin
                        xc = xc + ysh;
                        yc = yc - xsh;
                        zc = zc + cbd_pkg::atan_tab(s * SPS + j);
                    end
                    else begin
                        xc = xc - ysh;
                        yc = yc + xsh;
                        zc = zc - cbd_pkg::atan_tab(s * SPS + j);
                    end
                end
            end
            x_next[s+1]     = xc;
            y_next[s+1]     = yc;
            z_next[s+1]     = zc;
            zero_next[s+1]  = zero_reg[s];
            valid_next[s+1] = valid_reg[s];
        end
    end

    // Round stage: round the angle to 8 fraction bits (ties up), take 90 minus it.
    always_comb
    begin
        logic signed [ZW-1:0] zr;
        zr          = z_reg[NCS] + cbd_pkg::ROUND_ADD;
        raw_next    = cbd_pkg::RAW_90 - (zr >>> 8);
        rzero_next  = zero_reg[NCS];
        rvalid_next = valid_reg[NCS];
    end

    // Wrap stage: truncate toward zero to whole degrees, fold into 0..359.
    always_comb
    begin
        logic                   neg;
        logic [ZW-1:0]          mag;
        logic [ZW-9:0]          q;
        logic signed [DEGW-1:0] deg;
        neg = raw_reg[ZW-1];
        mag = neg ? unsigned'(-raw_reg) : unsigned'(raw_reg);
        q   = mag[ZW-1:8];
        deg = neg ? -DEGW'(q) : DEGW'(q);
        if (deg < 0) begin
            deg = deg + cbd_pkg::DEG_360;
        end
        else if (deg >= cbd_pkg::DEG_360) begin
            deg = deg - cbd_pkg::DEG_360;
        end
        // equal points have no direction: report east
        bearing_next = rzero_reg ? cbd_pkg::BEARING_EQUAL : deg[cbd_pkg::BEARING_WIDTH-1:0];
        done_next    = rvalid_reg;
    end

    // Control state: valid bits and done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else begin
            valid_reg  <= valid_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
        end
    end

    // Payload: advance every cycle, no reset needed.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= NCS; s++) begin
            x_reg[s]    <= x_next[s];
            y_reg[s]    <= y_next[s];
            z_reg[s]    <= z_next[s];
            zero_reg[s] <= zero_next[s];
        end
        raw_reg     <= raw_next;
        rzero_reg   <= rzero_next;
        bearing_reg <= bearing_next;
    end

    assign done    = done_reg;
    assign bearing = bearing_reg;

endmodule

// ----- rtl/core/cbd_checker.sv -----
// cbd_checker: port-level assertions for compass_bearing_degrees_top, with its bind.
// Depends on cbd_pkg for the coordinate width and the pipeline latency.
module cbd_checker (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     start,
    input logic                                     busy,
    input logic signed [cbd_pkg::COORD_WIDTH-1:0]   start_x,
    input logic signed [cbd_pkg::COORD_WIDTH-1:0]   start_y,
    input logic signed [cbd_pkg::COORD_WIDTH-1:0]   end_x,
    input logic signed [cbd_pkg::COORD_WIDTH-1:0]   end_y,
    input logic                                     done,
    input logic        [cbd_pkg::BEARING_WIDTH-1:0] bearing
);

    // every accepted word comes out after the fixed latency
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(cbd_pkg::LATENCY) done)
        else $error("accepted word produced no result");

    // no result without a word accepted one latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(cbd_pkg::LATENCY) !done)
        else $error("result without accepted word");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (bearing < 9'd360))
        else $error("bearing out of range");

    // equal points report 90
    a_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && start_x == end_x && start_y == end_y)
        |-> ##(cbd_pkg::LATENCY) (bearing == 9'd90))
        else $error("equal points not 90");

    // due west reports 270
    a_west: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && start_y == end_y && $signed(end_x) < $signed(start_x))
        |-> ##(cbd_pkg::LATENCY) (bearing == 9'd270))
        else $error("due west not 270");

endmodule

bind compass_bearing_degrees_top cbd_checker u_cbd_checker (.*);

// ----- dv/compass_bearing_degrees_top_test.sv -----
// compass_bearing_degrees_top_test: self-checking bench for the CORDIC bearing block.
// Depends on cbd_pkg and compass_bearing_degrees_top; drives random and corner point pairs
// and checks every bearing against an in-bench fixed-point atan2 predictor.
module compass_bearing_degrees_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [cbd_pkg::COORD_WIDTH-1:0] coord_t;
    typedef logic [cbd_pkg::BEARING_WIDTH-1:0] bearing_t;

    // One point pair waiting to go out, with the pacing the driver uses for it.
    typedef struct packed {
        coord_t     sx;
        coord_t     sy;
        coord_t     ex;
        coord_t     ey;
        logic [6:0] idle_pct;   // chance in percent that the driver holds off a cycle
        logic       drain;      // hold this word until every bearing in flight is back
    } point_pair_t;

    // A bearing owed by the block, with the points it came from for the report.
    typedef struct packed {
        coord_t   sx;
        coord_t   sy;
        coord_t   ex;
        coord_t   ey;
        bearing_t bearing;
    } bearing_owed_t;

    // Cycles with neither a word taken nor a bearing seen before the run is called hung.
    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_LIMIT = 100;
    localparam int RANDOM_PER_PHASE = 610;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    coord_t   start_x = '0;
    coord_t   start_y = '0;
    coord_t   end_x = '0;
    coord_t   end_y = '0;
    logic     busy;
    logic     done;
    bearing_t bearing;

    point_pair_t   words_to_send [$];
    bearing_owed_t bearings_due [$];
    int unsigned   words_sent = 0;
    int unsigned   bearings_checked = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles = 0;

    // atan(2^-k) in degrees with 16 fraction bits, rounded to nearest.
    longint atan_deg16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    compass_bearing_degrees_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .done    (done),
        .bearing (bearing)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Predict the bearing: vectoring CORDIC on (dx, dy) in 64-bit fixed point,
    // then round to 1/256 degree, take 90 minus it, truncate toward zero and wrap into 0..359.
    function automatic bearing_t predict_bearing(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        longint rise;
        longint run;
        longint vx;
        longint vy;
        longint ang;
        longint shx;
        longint shy;
        longint tmp;
        longint ang8;
        longint raw;
        longint deg;
        int     k;
        rise = longint'(sy) - longint'(ey);
        run  = longint'(ex) - longint'(sx);
        // equal points point east by convention
        if (rise == 0 && run == 0)
            return bearing_t'(90);
        vx  = run <<< cbd_pkg::PRESCALE;
        vy  = rise <<< cbd_pkg::PRESCALE;
        ang = 0;
        // rotate left half-plane vectors by a quarter turn so CORDIC converges
        if (vx < 0) begin
            if (vy >= 0) begin
                tmp = vx;
                vx  = vy;
                vy  = -tmp;
                ang = 90 * 65536;
            end
            else begin
                tmp = vx;
                vx  = -vy;
                vy  = tmp;
                ang = -90 * 65536;
            end
        end
        for (k = 0; k < cbd_pkg::CORDIC_STEPS && k < 24; k++) begin
            shx = vx >>> k;
            shy = vy >>> k;
            if (vy >= 0) begin
                vx  = vx + shy;
                vy  = vy - shx;
                ang = ang + atan_deg16[k];
            end
            else begin
                vx  = vx - shy;
                vy  = vy + shx;
                ang = ang - atan_deg16[k];
            end
        end
        ang8 = (ang + 128) >>> 8;
        raw  = 90 * 256 - ang8;
        deg  = (raw >= 0) ? (raw >>> 8) : -((-raw) >>> 8);
        while (deg < 0)
            deg = deg + 360;
        while (deg >= 360)
            deg = deg - 360;
        return bearing_t'(deg);
    endfunction

    task automatic queue_pair(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                              int unsigned idle_pct, bit drain);
        point_pair_t p;
        p.sx       = sx;
        p.sy       = sy;
        p.ex       = ex;
        p.ey       = ey;
        p.idle_pct = 7'(idle_pct);
        p.drain    = drain;
        words_to_send.push_back(p);
    endtask

    // Pick a start point, then an end point by one of several offset shapes so that
    // axes, diagonals, near-axis slivers and tiny vectors all show up often.
    task automatic queue_random_pair(int unsigned idle_pct, bit drain);
        coord_t sx;
        coord_t sy;
        int     ddx;
        int     ddy;
        int     mag;
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        case ($urandom_range(0, 5))
            0, 1: begin
                ddx = int'(coord_t'($urandom));
                ddy = int'(coord_t'($urandom));
            end
            2: begin
                ddx = int'($urandom_range(0, 32)) - 16;
                ddy = int'($urandom_range(0, 32)) - 16;
            end
            3: begin
                // sliver next to an axis, either way round
                ddx = int'($urandom_range(0, 6)) - 3;
                ddy = int'($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 1) == 1) begin
                    mag = ddx;
                    ddx = ddy;
                    ddy = mag;
                end
            end
            4: begin
                mag = int'($urandom_range(0, 32767));
                ddx = ($urandom_range(0, 1) == 1) ? mag : -mag;
                ddy = ($urandom_range(0, 1) == 1) ? mag : -mag;
                ddx = ddx + int'($urandom_range(0, 2)) - 1;
            end
            default: begin
                // exact axis: one difference is zero
                mag = int'($urandom_range(0, 65535)) - 32768;
                ddx = ($urandom_range(0, 1) == 1) ? mag : 0;
                ddy = (ddx == 0) ? mag : 0;
            end
        endcase
        queue_pair(sx, sy, coord_t'(int'(sx) + ddx), coord_t'(int'(sy) + ddy), idle_pct, drain);
    endtask

    // Driver: present the next word when the slot is free, rolling the idle chance
    // of that word each cycle. Hold a drain word until the pipeline is empty.
    always @(posedge clk or negedge rst_n) begin : drive_words
        logic        taken;
        point_pair_t nxt;
        if (!rst_n) begin
            start   <= 1'b0;
            start_x <= '0;
            start_y <= '0;
            end_x   <= '0;
            end_y   <= '0;
        end
        else begin
            taken = start && !busy;
            if (!start || taken) begin
                if (words_to_send.size() != 0
                    && !(words_to_send[0].drain && (taken || bearings_due.size() != 0))
                    && $urandom_range(0, 99) >= words_to_send[0].idle_pct) begin
                    nxt = words_to_send.pop_front();
                    start   <= 1'b1;
                    start_x <= nxt.sx;
                    start_y <= nxt.sy;
                    end_x   <= nxt.ex;
                    end_y   <= nxt.ey;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check the bearing on the strobe against the oldest one owed first,
    // then log any word taken at this edge, so a word is never matched to itself.
    always @(posedge clk or negedge rst_n) begin : watch_bearings
        bearing_owed_t owed;
        logic          taken;
        if (!rst_n) begin
            quiet_cycles <= 0;
        end
        else begin
            taken = start && !busy;
            if (done) begin
                bearings_checked++;
                if (bearings_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: bearing %0d with no word outstanding", $time, bearing);
                end
                else begin
                    owed = bearings_due.pop_front();
                    if (bearing !== owed.bearing) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: bearing (%0d,%0d)->(%0d,%0d): expected %0d, actual %0d",
                                     $time, owed.sx, owed.sy, owed.ex, owed.ey,
                                     owed.bearing, bearing);
                    end
                end
            end
            if (taken) begin
                owed.sx      = start_x;
                owed.sy      = start_y;
                owed.ex      = end_x;
                owed.ey      = end_y;
                owed.bearing = predict_bearing(start_x, start_y, end_x, end_y);
                bearings_due.push_back(owed);
                words_sent++;
            end
            quiet_cycles <= (done || taken) ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : run_test
        int unsigned idle;
        bit          timed_out;
        timed_out = 1'b0;

        // Directed words: equal points, the four axes, the corners of the field,
        // slivers either side of north, south and west, and just north of east.
        queue_pair(0, 0, 0, 0, 0, 1'b0);
        queue_pair(-32768, -32768, -32768, -32768, 0, 1'b0);
        queue_pair(32767, 32767, 32767, 32767, 0, 1'b0);
        queue_pair(0, 100, 0, -100, 0, 1'b0);               // due north
        queue_pair(-100, 0, 100, 0, 0, 1'b0);               // due east
        queue_pair(0, -100, 0, 100, 0, 1'b0);               // due south
        queue_pair(100, 0, -100, 0, 0, 1'b0);               // due west
        queue_pair(0, 0, -1, 0, 0, 1'b0);                   // one step west
        queue_pair(-32768, -32768, 32767, 32767, 0, 1'b0);  // southeast, full span
        queue_pair(32767, 32767, -32768, -32768, 0, 1'b0);  // northwest, full span
        queue_pair(32767, -32768, -32768, 32767, 0, 1'b0);  // southwest, full span
        queue_pair(-32768, 32767, 32767, -32768, 0, 1'b0);  // northeast, full span
        queue_pair(0, 32767, -1, -32768, 0, 1'b0);          // just west of north: small negative raw
        queue_pair(0, 32767, 1, -32768, 0, 1'b0);           // just east of north
        queue_pair(0, -32768, -1, 32767, 0, 1'b0);          // just west of south
        queue_pair(0, -32768, 1, 32767, 0, 1'b0);           // just east of south
        queue_pair(32767, 0, -32768, 1, 0, 1'b0);           // just south of west
        queue_pair(32767, 1, -32768, 0, 0, 1'b0);           // just north of west
        queue_pair(-32768, 0, 32767, -1, 0, 1'b0);          // just north of east
        queue_pair(-1, -1, 0, 0, 0, 1'b0);
        queue_pair(32767, -32768, 32767, 32767, 0, 1'b0);
        queue_pair(-32768, 32767, -32768, -32768, 0, 1'b0);
        queue_pair(-1, 0, -32768, -1, 0, 1'b0);

        // Random phases: back to back, sender mostly idle, sender lightly idle.
        // Open each phase with a drained pipeline and sprinkle short full-rate bursts.
        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                case (phase)
                    1: idle = 84;
                    2: idle = 21;
                    default: idle = 0;
                endcase
                if (n % 48 < 10)
                    idle = 0;
                queue_random_pair(idle, n == 0 || $urandom_range(0, 199) == 0);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every word to go out and every bearing to come back.
        while (!timed_out
               && !(words_to_send.size() == 0 && !start && bearings_due.size() == 0)) begin
            @(negedge clk);
            if (quiet_cycles >= QUIET_LIMIT)
                timed_out = 1'b1;
        end

        // Let the pipeline run dry so a stray strobe still gets caught.
        if (!timed_out)
            repeat (cbd_pkg::LATENCY + 8) @(negedge clk);

        if (!timed_out && mismatch_count == 0 && bearings_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
